/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ITP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ITP_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/itp_pkg.sv */
// Shared constants, codes and types for the infix to postfix converter.
// No dependencies.
package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = 3;

  // token kinds on the input channel
  localparam logic [2:0] TOK_NUM = 3'd0;
  localparam logic [2:0] TOK_OPR = 3'd1;
  localparam logic [2:0] TOK_LP  = 3'd2;
  localparam logic [2:0] TOK_RP  = 3'd3;
  localparam logic [2:0] TOK_END = 3'd4;

  // stack entry for a left parenthesis; operators are stored as their code
  localparam logic [ENTRY_W-1:0] ENT_LPAREN = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_NUM = 2'd0;
  localparam logic [1:0] KIND_OPR = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNMATCH  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUM,
    S_OPR,
    S_LP,
    S_RP,
    S_END
  } state_t;

  typedef struct packed {
    logic               we;
    logic [SP_W-1:0]    waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [SP_W-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [1:0]             arith;
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             err;
    logic                   last;
  } res_beat_t;

  // true when stacked entry must leave before incoming operator is pushed
  function automatic logic pops_before(input logic [ENTRY_W-1:0] stacked,
                                       input logic [1:0]         incoming);
    return (stacked != ENT_LPAREN) && (stacked[1] || !incoming[1]);
  endfunction

endpackage

/* hw/rtl/itp_if.sv */
// Valid/ready channel interfaces: token input and postfix result output.
// Depends on itp_pkg.
interface itp_tok_if import itp_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [2:0]             op;
  logic [1:0]             arith;
  logic [VALUE_WIDTH-1:0] number_value;

  modport source (output valid, op, arith, number_value, input ready);
  modport sink   (input valid, op, arith, number_value, output ready);
endinterface

interface itp_res_if import itp_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [1:0]             out_kind;
  logic [1:0]             out_arith;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [1:0]             error_code;
  logic                   last;

  modport source (output valid, out_kind, out_arith, out_value, error_code, last,
                  input ready);
  modport sink   (input valid, out_kind, out_arith, out_value, error_code, last,
                  output ready);
endinterface

/* hw/rtl/infix_to_postfix_converter_top.sv */
// Top level of the shunting-yard infix to postfix converter.
// Depends on itp_pkg, itp_if, itp_stack_mem and itp_seq.
//
//   channel | dir | beat payload                                     | handshake
//   --------+-----+--------------------------------------------------+----------
//   tok     | in  | op, arith, number_value                          | valid/ready
//   res     | out | out_kind, out_arith, out_value, error_code, last | valid/ready
//
// A number is emitted and a left paren pushed; an operator pops each operator
//   that must leave, then is pushed; a right paren pops operators down to its
//   own left paren, which then comes off; an end token pops the stack unless an
//   error was seen, then emits the end beat. Ignored tokens are dropped. The
//   stack RAM gives one pop per cycle via its single read port unless stalled.
// Reset: synchronous, clears pointer, error flag, FSM and output valid; the
//   stack RAM is not cleared (only entries below the pointer are read).
// Stalls: results sit in an output register, so a token may be taken while a
//   result waits; the sequencer then holds until the register drains.
module infix_to_postfix_converter_top import itp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  itp_tok_if.sink   tok,
  itp_res_if.source res
);

  // read/write request from the sequencer to the stack RAM
  mem_req_t           mem_req;
  // registered read data: entry just below the cached top
  logic [ENTRY_W-1:0] rd_data;

  // Stack storage. Push writes the slot at the pointer; the read port is
  // always aimed at the slot two below the next pointer, which never meets a
  // write in the same cycle, so no forwarding is needed.
  itp_stack_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Token decode, pop runs, error handling and the output register.
  itp_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .tok     (tok),
    .res     (res),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

/* hw/rtl/itp_stack_mem.sv */
// Operator stack RAM: one write port, one read port, registered read data.
// Depends on itp_pkg.
module itp_stack_mem import itp_pkg::*; (
  input  logic               clk,
  input  mem_req_t           req,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

/* hw/rtl/itp_seq.sv */
// Shunting-yard sequencer: token latch, stack pointer, top-of-stack cache,
// error flag and the output register. Depends on itp_pkg and itp_if.
module itp_seq import itp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  itp_tok_if.sink            tok,
  itp_res_if.source          res,
  output mem_req_t           mem_req,
  input  logic [ENTRY_W-1:0] rd_data
);

  state_t                 state, state_next;
  logic [1:0]             t_ar;
  logic [VALUE_WIDTH-1:0] t_val;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [ENTRY_W-1:0]     top, top_next;
  logic                   err_seen, err_seen_next;
  logic                   ov;
  res_beat_t              beat, obeat;
  logic                   emit;
  logic                   can_load;
  logic                   has_below;
  logic                   full;
  logic                   accept;

  assign accept    = tok.valid && tok.ready;
  assign can_load  = !ov || res.ready;
  // rd_data always holds the entry just below top once cnt >= 2
  assign has_below = cnt > CNT_W'(1);
  assign full      = cnt == CNT_W'(STACK_DEPTH);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    top_next      = top;
    err_seen_next = err_seen;
    emit          = 1'b0;
    beat          = '{kind: KIND_NUM, arith: 2'd0, value: '0, err: ERR_NONE, last: 1'b0};
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt[SP_W-1:0];
    mem_req.wdata = top;
    tok.ready     = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (tok.valid) begin
          if (tok.op == TOK_END) begin
            state_next = S_END;
          end else if (!err_seen) begin
            case (tok.op)
              TOK_NUM: state_next = S_NUM;
              TOK_OPR: state_next = S_OPR;
              TOK_LP:  state_next = S_LP;
              TOK_RP:  state_next = S_RP;
              default: state_next = S_IDLE;
            endcase
          end
        end
      end

      S_NUM: begin
        if (can_load) begin
          emit       = 1'b1;
          beat.value = t_val;
          beat.last  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_OPR: begin
        if (cnt != '0 && pops_before(top, t_ar)) begin
          if (can_load) begin
            emit       = 1'b1;
            beat.kind  = KIND_OPR;
            beat.arith = top[1:0];
            // a pop always leaves room, so the push after the run is silent
            beat.last  = !(has_below && pops_before(rd_data, t_ar));
            cnt_next   = cnt - CNT_W'(1);
            top_next   = rd_data;
          end
        end else if (full) begin
          if (can_load) begin
            emit          = 1'b1;
            beat.kind     = KIND_ERR;
            beat.err      = ERR_OVERFLOW;
            beat.last     = 1'b1;
            err_seen_next = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = {1'b0, t_ar};
          top_next      = {1'b0, t_ar};
          cnt_next      = cnt + CNT_W'(1);
          state_next    = S_IDLE;
        end
      end

      S_LP: begin
        if (full) begin
          if (can_load) begin
            emit          = 1'b1;
            beat.kind     = KIND_ERR;
            beat.err      = ERR_OVERFLOW;
            beat.last     = 1'b1;
            err_seen_next = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = ENT_LPAREN;
          top_next      = ENT_LPAREN;
          cnt_next      = cnt + CNT_W'(1);
          state_next    = S_IDLE;
        end
      end

      S_RP: begin
        if (cnt == '0) begin
          if (can_load) begin
            emit          = 1'b1;
            beat.kind     = KIND_ERR;
            beat.err      = ERR_UNMATCH;
            beat.last     = 1'b1;
            err_seen_next = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (top == ENT_LPAREN) begin
          cnt_next   = cnt - CNT_W'(1);
          top_next   = rd_data;
          state_next = S_IDLE;
        end else if (can_load) begin
          emit       = 1'b1;
          beat.kind  = KIND_OPR;
          beat.arith = top[1:0];
          beat.last  = has_below && (rd_data == ENT_LPAREN);
          cnt_next   = cnt - CNT_W'(1);
          top_next   = rd_data;
        end
      end

      S_END: begin
        if (err_seen || cnt == '0) begin
          if (can_load) begin
            emit          = 1'b1;
            beat.kind     = KIND_END;
            beat.last     = 1'b1;
            cnt_next      = '0;
            err_seen_next = 1'b0;
            state_next    = S_IDLE;
          end
        end else if (top == ENT_LPAREN) begin
          cnt_next = cnt - CNT_W'(1);
          top_next = rd_data;
        end else if (can_load) begin
          emit       = 1'b1;
          beat.kind  = KIND_OPR;
          beat.arith = top[1:0];
          cnt_next   = cnt - CNT_W'(1);
          top_next   = rd_data;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // present the slot below the next top so it is ready next cycle
    mem_req.raddr = SP_W'(cnt_next - CNT_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      err_seen <= 1'b0;
      ov       <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      err_seen <= err_seen_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (accept) begin
      t_ar  <= tok.arith;
      t_val <= tok.number_value;
    end
    if (emit) begin
      obeat <= beat;
    end
  end

  assign res.valid      = ov;
  assign res.out_kind   = obeat.kind;
  assign res.out_arith  = obeat.arith;
  assign res.out_value  = obeat.value;
  assign res.error_code = obeat.err;
  assign res.last       = obeat.last;

endmodule

/* hw/rtl/itp_checker.sv */
// Port-level checks on the converter's result channel, with its bind.
// Depends on itp_pkg and assert_macros.svh.
module itp_checker import itp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [1:0]             out_kind,
  input logic [1:0]             out_arith,
  input logic [VALUE_WIDTH-1:0] out_value,
  input logic [1:0]             error_code,
  input logic                   last
);
`include "assert_macros.svh"

  `ITP_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(out_kind) && $stable(out_arith) && $stable(out_value) && $stable(last), "result beat changed while stalled")
  `ITP_ASSERT_RST(a_rst_quiet, rst |=> !res_valid, "result valid straight after reset")
  `ITP_ASSERT(a_err_final, res_valid && out_kind == KIND_ERR |-> last && (error_code == ERR_OVERFLOW || error_code == ERR_UNMATCH), "error beat lacks code or last")
  `ITP_ASSERT(a_end_final, res_valid && out_kind == KIND_END |-> last && error_code == ERR_NONE, "end beat not final or carries error")

endmodule

bind infix_to_postfix_converter_top itp_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .out_kind   (res.out_kind),
  .out_arith  (res.out_arith),
  .out_value  (res.out_value),
  .error_code (res.error_code),
  .last       (res.last)
);
